>>> rtl/yuyvbr_pkg.sv
// ----------------------------------------------------------------------------
// yuyvbr_pkg
// Shared constants for the YUYV bilinear resampler: store geometry, field
// widths, fixed-point format and configuration register indexes.
// ----------------------------------------------------------------------------
package yuyvbr_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int FRACTION_BITS = 16;

  // store depth in words, two pixels per word
  localparam int STORE_DEPTH = (MAX_WIDTH / 2) * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  // each bank holds every other word
  localparam int BANK_ADDR_W = ADDR_W - 1;
  localparam int WORD_W      = 32;
  localparam int LANE_W      = 8;
  localparam int LANES       = WORD_W / LANE_W;

  // configuration register widths
  localparam int SRC_WIDTH_W = 11;
  localparam int STEP_W      = 27;
  localparam int STRIDE_W    = SRC_WIDTH_W - 1;
  localparam int CFG_DATA_W  = STEP_W;
  localparam int CFG_INDEX_W = 2;

  // input / output field widths
  localparam int ROW_W = 10;
  localparam int COL_W = 9;

  // fixed-point products
  localparam int PX_W  = STEP_W + COL_W;
  localparam int PY_W  = STEP_W + ROW_W;
  localparam int FRAC1_W = FRACTION_BITS + 1;       // holds 1.0
  localparam int WGT_W = 2 * FRACTION_BITS + 1;     // holds 1.0 * 1.0
  localparam int TERM_W = WGT_W + LANE_W;
  localparam int SUM_W  = TERM_W + 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH = 2'd0,
    REG_X_STEP       = 2'd1,
    REG_Y_STEP       = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

endpackage

>>> rtl/yuyvbr_ram.sv
// ----------------------------------------------------------------------------
// yuyvbr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module yuyvbr_ram #(
  parameter int ADDR_BITS = 18,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/yuyv_bilinear_resampler_core.sv
// ----------------------------------------------------------------------------
// yuyv_bilinear_resampler_core
// Bilinear resampler over a packed YUYV frame store, six-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_stall is low, loads and samples alike,
// and returns one interpolated word per sample; loads give no word. The four
// neighbor reads of a sample all happen in the same cycle because the
// store is kept in two copies (top row, row below), each split into even and
// odd word banks, so every bank sees a single read. Loads write all copies in
// the same stage where samples read, so a sample always sees every load taken
// before it. Each stage has its own valid bit and holds only when the stage
// after it is full and holding, so bubbles close up under output stall.
module yuyv_bilinear_resampler_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 write_enable,
  input  logic [yuyvbr_pkg::CFG_INDEX_W-1:0]   register_index,
  input  logic [yuyvbr_pkg::CFG_DATA_W-1:0]    write_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [yuyvbr_pkg::ADDR_W-1:0]        word_address,
  input  logic [yuyvbr_pkg::WORD_W-1:0]        source_word,
  input  logic [yuyvbr_pkg::ROW_W-1:0]         target_row,
  input  logic [yuyvbr_pkg::COL_W-1:0]         target_column,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [yuyvbr_pkg::WORD_W-1:0]        result_word,
  output logic [yuyvbr_pkg::ROW_W-1:0]         result_row,
  output logic [yuyvbr_pkg::COL_W-1:0]         result_column
);

  localparam int F   = yuyvbr_pkg::FRACTION_BITS;
  localparam int AW  = yuyvbr_pkg::ADDR_W;
  localparam int BAW = yuyvbr_pkg::BANK_ADDR_W;
  localparam int WW  = yuyvbr_pkg::WORD_W;
  localparam int LW  = yuyvbr_pkg::LANE_W;
  localparam int NL  = yuyvbr_pkg::LANES;
  localparam int RW  = yuyvbr_pkg::ROW_W;
  localparam int CW  = yuyvbr_pkg::COL_W;
  localparam int SW  = yuyvbr_pkg::STRIDE_W;
  localparam int GW  = yuyvbr_pkg::WGT_W;
  localparam int TW  = yuyvbr_pkg::TERM_W;
  localparam int UW  = yuyvbr_pkg::SUM_W;
  localparam int F1W = yuyvbr_pkg::FRAC1_W;
  localparam logic [F1W-1:0] ONE = F1W'(1) << F;

  // configuration registers
  logic [yuyvbr_pkg::SRC_WIDTH_W-1:0] source_width;
  logic [yuyvbr_pkg::STEP_W-1:0]      x_step;
  logic [yuyvbr_pkg::STEP_W-1:0]      y_step;
  logic [SW-1:0]                      stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= yuyvbr_pkg::SRC_WIDTH_W'(640);
      x_step       <= '0;
      y_step       <= '0;
    end else if (write_enable) begin
      case (register_index)
        yuyvbr_pkg::REG_SOURCE_WIDTH: source_width <= write_data[yuyvbr_pkg::SRC_WIDTH_W-1:0];
        yuyvbr_pkg::REG_X_STEP:       x_step       <= write_data[yuyvbr_pkg::STEP_W-1:0];
        yuyvbr_pkg::REG_Y_STEP:       y_step       <= write_data[yuyvbr_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign stride = source_width[yuyvbr_pkg::SRC_WIDTH_W-1:1];

  // stage valid bits and advance enables
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6     = !v6 || !out_stall;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  // ---------------- stage 1: position products
  logic               s1_sample;
  logic [AW-1:0]      s1_addr;
  logic [WW-1:0]      s1_word;
  logic [RW-1:0]      s1_row;
  logic [CW-1:0]      s1_col;
  logic [yuyvbr_pkg::PX_W-1:0] s1_px;
  logic [yuyvbr_pkg::PY_W-1:0] s1_py;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sample <= (action == yuyvbr_pkg::ACT_SAMPLE);
      s1_addr   <= word_address;
      s1_word   <= source_word;
      s1_row    <= target_row;
      s1_col    <= target_column;
      s1_px     <= yuyvbr_pkg::PX_W'(x_step) * yuyvbr_pkg::PX_W'(target_column);
      s1_py     <= yuyvbr_pkg::PY_W'(y_step) * yuyvbr_pkg::PY_W'(target_row);
    end
  end

  // ---------------- stage 2: row offset and blend weights
  logic           s2_sample;
  logic [AW-1:0]  s2_addr;
  logic [WW-1:0]  s2_word;
  logic [RW-1:0]  s2_row;
  logic [CW-1:0]  s2_col;
  logic [AW-1:0]  s2_x;
  logic [AW-1:0]  s2_rowoff;
  logic [GW-1:0]  s2_wgt [4];

  logic [AW-1:0]  y_lo;
  logic [F1W-1:0] inv_dx, inv_dy, frac_dx, frac_dy;

  assign y_lo    = AW'(s1_py >> F);
  assign frac_dx = F1W'(s1_px[F-1:0]);
  assign frac_dy = F1W'(s1_py[F-1:0]);
  assign inv_dx  = ONE - frac_dx;
  assign inv_dy  = ONE - frac_dy;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_sample <= s1_sample;
      s2_addr   <= s1_addr;
      s2_word   <= s1_word;
      s2_row    <= s1_row;
      s2_col    <= s1_col;
      s2_x      <= AW'(s1_px >> F);
      s2_rowoff <= y_lo * AW'(stride);      // wraps modulo store depth
      s2_wgt[0] <= GW'(inv_dx * inv_dy);
      s2_wgt[1] <= GW'(frac_dx * inv_dy);
      s2_wgt[2] <= GW'(inv_dx * frac_dy);
      s2_wgt[3] <= GW'(frac_dx * frac_dy);
    end
  end

  // ---------------- stage 3: bank addresses
  logic           s3_sample;
  logic [AW-1:0]  s3_addr;
  logic [WW-1:0]  s3_word;
  logic [RW-1:0]  s3_row;
  logic [CW-1:0]  s3_col;
  logic [GW-1:0]  s3_wgt [4];
  logic [BAW-1:0] s3_top_even, s3_top_odd, s3_bot_even, s3_bot_odd;
  logic           s3_top_swap, s3_bot_swap;

  logic [AW-1:0]  base_top, base_bot;

  assign base_top = s2_rowoff + s2_x;
  assign base_bot = s2_rowoff + s2_x + AW'(stride);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sample   <= s2_sample;
      s3_addr     <= s2_addr;
      s3_word     <= s2_word;
      s3_row      <= s2_row;
      s3_col      <= s2_col;
      s3_wgt      <= s2_wgt;
      // odd base: left word sits in the odd bank, right word in the next even
      s3_top_odd  <= base_top[AW-1:1];
      s3_top_even <= base_top[AW-1:1] + BAW'(base_top[0]);
      s3_top_swap <= base_top[0];
      s3_bot_odd  <= base_bot[AW-1:1];
      s3_bot_even <= base_bot[AW-1:1] + BAW'(base_bot[0]);
      s3_bot_swap <= base_bot[0];
    end
  end

  // ---------------- stage 4: store access
  logic          mem_we_even, mem_we_odd, mem_re;
  logic [WW-1:0] rd_top_even, rd_top_odd, rd_bot_even, rd_bot_odd;

  assign mem_re      = rdy4 && v3 && s3_sample;
  assign mem_we_even = rdy4 && v3 && !s3_sample && !s3_addr[0];
  assign mem_we_odd  = rdy4 && v3 && !s3_sample &&  s3_addr[0];

  yuyvbr_ram #(.ADDR_BITS(BAW), .DATA_BITS(WW)) u_top_even (
    .clk(clk), .we(mem_we_even), .waddr(s3_addr[AW-1:1]), .wdata(s3_word),
    .re(mem_re), .raddr(s3_top_even), .rdata(rd_top_even)
  );
  yuyvbr_ram #(.ADDR_BITS(BAW), .DATA_BITS(WW)) u_top_odd (
    .clk(clk), .we(mem_we_odd), .waddr(s3_addr[AW-1:1]), .wdata(s3_word),
    .re(mem_re), .raddr(s3_top_odd), .rdata(rd_top_odd)
  );
  yuyvbr_ram #(.ADDR_BITS(BAW), .DATA_BITS(WW)) u_bot_even (
    .clk(clk), .we(mem_we_even), .waddr(s3_addr[AW-1:1]), .wdata(s3_word),
    .re(mem_re), .raddr(s3_bot_even), .rdata(rd_bot_even)
  );
  yuyvbr_ram #(.ADDR_BITS(BAW), .DATA_BITS(WW)) u_bot_odd (
    .clk(clk), .we(mem_we_odd), .waddr(s3_addr[AW-1:1]), .wdata(s3_word),
    .re(mem_re), .raddr(s3_bot_odd), .rdata(rd_bot_odd)
  );

  logic          s4_top_swap, s4_bot_swap;
  logic [RW-1:0] s4_row;
  logic [CW-1:0] s4_col;
  logic [GW-1:0] s4_wgt [4];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_top_swap <= s3_top_swap;
      s4_bot_swap <= s3_bot_swap;
      s4_row      <= s3_row;
      s4_col      <= s3_col;
      s4_wgt      <= s3_wgt;
    end
  end

  // ---------------- stage 5: lane times weight
  logic [WW-1:0] nb [4];
  logic [RW-1:0] s5_row;
  logic [CW-1:0] s5_col;
  logic [TW-1:0] s5_term [NL][4];

  assign nb[0] = s4_top_swap ? rd_top_odd  : rd_top_even;
  assign nb[1] = s4_top_swap ? rd_top_even : rd_top_odd;
  assign nb[2] = s4_bot_swap ? rd_bot_odd  : rd_bot_even;
  assign nb[3] = s4_bot_swap ? rd_bot_even : rd_bot_odd;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_row <= s4_row;
      s5_col <= s4_col;
      for (int l = 0; l < NL; l++) begin
        for (int n = 0; n < 4; n++) begin
          s5_term[l][n] <= TW'(nb[n][l*LW +: LW]) * TW'(s4_wgt[n]);
        end
      end
    end
  end

  // ---------------- stage 6: lane sums, truncate, pack
  logic [WW-1:0] packed_word;

  always_comb begin
    logic [UW-1:0] sum;
    packed_word = '0;
    for (int l = 0; l < NL; l++) begin
      sum = UW'(s5_term[l][0]) + UW'(s5_term[l][1])
          + UW'(s5_term[l][2]) + UW'(s5_term[l][3]);
      packed_word[l*LW +: LW] = sum[2*F +: LW];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      result_word   <= packed_word;
      result_row    <= s5_row;
      result_column <= s5_col;
    end
  end

  // valid bits; loads leave the pipe after the store stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3 && s3_sample;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  assign out_valid = v6;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YUYV bilinear resampler core. Source words are
// loaded into the frame store before any sample reads them. Expected output
// words come from a bit-exact fixed-point scoreboard. Both handshakes idle at
// random, and the run passes through several register settings, extremes
// included.
// ----------------------------------------------------------------------------
module tb_top;
  import yuyvbr_pkg::*;

  localparam int IDLE_LIMIT        = 4000;
  localparam int SETTLE_CYCLES     = 12;
  localparam int ITEMS_PER_SETTING = 220;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  typedef struct {
    action_t             act;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   word;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
  } source_item_t;

  typedef struct {
    logic [WORD_W-1:0]   word;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
  } result_t;

  typedef enum {FILL_MISSING, FILL_ONES} fill_t;

  // mirror of the store and registers; predicts one output word per sample
  class resample_scoreboard;
    logic [WORD_W-1:0]      frame_copy [logic [ADDR_W-1:0]];
    logic [SRC_WIDTH_W-1:0] width_reg;
    logic [STEP_W-1:0]      xstep_reg, ystep_reg;
    result_t                pending_words[$];
    int                     errors;

    function new();
      width_reg = 11'd640;
      xstep_reg = '0;
      ystep_reg = '0;
      errors    = 0;
    endfunction

    // top-left neighbor, before wrapping to the store depth
    static function logic [63:0] sample_base(logic [SRC_WIDTH_W-1:0] w,
                                             logic [STEP_W-1:0] xs, ys,
                                             logic [ROW_W-1:0] row,
                                             logic [COL_W-1:0] col);
      logic [63:0] px, py;
      px = 64'(xs) * 64'(col);
      py = 64'(ys) * 64'(row);
      return (py >> FRACTION_BITS) * 64'(w >> 1) + (px >> FRACTION_BITS);
    endfunction

    function logic [WORD_W-1:0] fetch(logic [63:0] addr);
      logic [ADDR_W-1:0] a;
      a = ADDR_W'(addr);
      return frame_copy.exists(a) ? frame_copy[a] : '0;
    endfunction

    function logic [LANE_W-1:0] mix_lane(logic [WORD_W-1:0] a, b, c, d,
                                         logic [63:0] dx, dy, int shift);
      logic [63:0] one, la, lb, lc, ld, sum;
      one = 64'd1 << FRACTION_BITS;
      la  = 64'(a[shift +: LANE_W]);
      lb  = 64'(b[shift +: LANE_W]);
      lc  = 64'(c[shift +: LANE_W]);
      ld  = 64'(d[shift +: LANE_W]);
      sum = la * (one - dx) * (one - dy) + lb * dx * (one - dy)
          + lc * dy * (one - dx) + ld * dx * dy;
      return LANE_W'(sum >> (2 * FRACTION_BITS));
    endfunction

    function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SOURCE_WIDTH: width_reg = data[SRC_WIDTH_W-1:0];
        REG_X_STEP:       xstep_reg = data[STEP_W-1:0];
        REG_Y_STEP:       ystep_reg = data[STEP_W-1:0];
        default: ;  // spare index, write dropped
      endcase
    endfunction

    function void note_input(source_item_t it);
      logic [63:0]       px, py, dx, dy, base, stride;
      logic [WORD_W-1:0] a, b, c, d;
      result_t           due;
      if (it.act == ACT_LOAD) begin
        frame_copy[it.addr] = it.word;
      end else begin
        px     = 64'(xstep_reg) * 64'(it.col);
        py     = 64'(ystep_reg) * 64'(it.row);
        dx     = px & ((64'd1 << FRACTION_BITS) - 64'd1);
        dy     = py & ((64'd1 << FRACTION_BITS) - 64'd1);
        base   = sample_base(width_reg, xstep_reg, ystep_reg, it.row, it.col);
        stride = 64'(width_reg >> 1);
        a = fetch(base);
        b = fetch(base + 64'd1);
        c = fetch(base + stride);
        d = fetch(base + stride + 64'd1);
        for (int lane = 0; lane < LANES; lane++) begin
          due.word[lane*LANE_W +: LANE_W] = mix_lane(a, b, c, d, dx, dy, lane * LANE_W);
        end
        due.row = it.row;
        due.col = it.col;
        pending_words.push_back(due);
      end
    endfunction

    function void check_result(logic [WORD_W-1:0] word, logic [ROW_W-1:0] row,
                               logic [COL_W-1:0] col);
      result_t due;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h row %0d column %0d", $time, word, row, col);
      end else begin
        due = pending_words.pop_front();
        if (word !== due.word) begin
          errors++;
          $display("%0t: result_word expected %h actual %h (row %0d column %0d)",
                   $time, due.word, word, due.row, due.col);
        end
        if (row !== due.row) begin
          errors++;
          $display("%0t: result_row expected %0d actual %0d", $time, due.row, row);
        end
        if (col !== due.col) begin
          errors++;
          $display("%0t: result_column expected %0d actual %0d", $time, due.col, col);
        end
      end
    endfunction

    function void report_leftovers();
      if (pending_words.size() != 0) begin
        errors++;
        $display("%0t: expected %0d more words, actual 0", $time, pending_words.size());
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst            = 1'b1;
  logic                    write_enable   = 1'b0;
  logic [CFG_INDEX_W-1:0]  register_index = '0;
  logic [CFG_DATA_W-1:0]   write_data     = '0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  action_t                 action         = ACT_LOAD;
  logic [ADDR_W-1:0]       word_address   = '0;
  logic [WORD_W-1:0]       source_word    = '0;
  logic [ROW_W-1:0]        target_row     = '0;
  logic [COL_W-1:0]        target_column  = '0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic [WORD_W-1:0]       result_word;
  logic [ROW_W-1:0]        result_row;
  logic [COL_W-1:0]        result_column;

  yuyv_bilinear_resampler_core dut (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .word_address   (word_address),
    .source_word    (source_word),
    .target_row     (target_row),
    .target_column  (target_column),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_word    (result_word),
    .result_row     (result_row),
    .result_column  (result_column)
  );

  resample_scoreboard sb = new();

  // stimulus-side view of the registers and of which words hold data
  logic [SRC_WIDTH_W-1:0] gen_width = 11'd640;
  logic [STEP_W-1:0]      gen_xstep = '0;
  logic [STEP_W-1:0]      gen_ystep = '0;
  bit                     written_map [STORE_DEPTH];
  logic [ROW_W-1:0]       last_row = '0;
  logic [COL_W-1:0]       last_col = '0;
  int                     words_sent    = 0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  int                     send_calm     = 0;
  int                     recv_calm     = 0;
  int                     quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stall with occasional stall-free runs
  always @(posedge clk) begin
    if (recv_calm > 0) begin
      recv_calm <= recv_calm - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(39) == 0) begin
      recv_calm <= int'($urandom_range(10, 40));
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    source_item_t seen;
    bit           moved;
    moved = 1'b0;
    if (!rst) begin
      if (write_enable) begin
        sb.note_config(register_index, write_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        seen.act  = action;
        seen.addr = word_address;
        seen.word = source_word;
        seen.row  = target_row;
        seen.col  = target_column;
        sb.note_input(seen);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(result_word, result_row, result_column);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // k: 0 top-left, 1 right, 2 below, 3 below-right
  function automatic logic [ADDR_W-1:0] neighbor_addr(logic [ROW_W-1:0] row,
                                                      logic [COL_W-1:0] col, int k);
    logic [63:0] base, stride;
    base   = resample_scoreboard::sample_base(gen_width, gen_xstep, gen_ystep, row, col);
    stride = 64'(gen_width >> 1);
    return ADDR_W'(base + ((k >= 2) ? stride : 64'd0) + 64'(k & 1));
  endfunction

  task automatic send_item(input source_item_t it);
    bit gap;
    gap = 1'b1;
    while (gap) begin
      if (send_calm > 0) begin
        send_calm--;
        gap = 1'b0;
      end else if ($urandom_range(39) == 0) begin
        send_calm = int'($urandom_range(10, 40));
        gap = 1'b0;
      end else begin
        gap = ($urandom_range(99) < send_idle_pct);
      end
      if (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    action        <= it.act;
    word_address  <= it.addr;
    source_word   <= it.word;
    target_row    <= it.row;
    target_column <= it.col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_load(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
    source_item_t it;
    it.act  = ACT_LOAD;
    it.addr = addr;
    it.word = data;
    it.row  = ROW_W'($urandom);
    it.col  = COL_W'($urandom);
    written_map[addr] = 1'b1;
    send_item(it);
  endtask

  // loads whatever the four neighbors still lack (all four with ones under FILL_ONES), then asks for the word
  task automatic prepare_and_sample(input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col, input fill_t fill);
    logic [ADDR_W-1:0] spot;
    source_item_t      it;
    for (int k = 0; k < 4; k++) begin
      spot = neighbor_addr(row, col, k);
      if (fill == FILL_ONES) send_load(spot, '1);
      else if (!written_map[spot]) send_load(spot, random_word());
    end
    it.act  = ACT_SAMPLE;
    it.addr = ADDR_W'($urandom);
    it.word = WORD_W'($urandom);
    it.row  = row;
    it.col  = col;
    send_item(it);
    last_row = row;
    last_col = col;
  endtask

  task automatic program_registers(input logic [SRC_WIDTH_W-1:0] w,
                                   input logic [STEP_W-1:0] xs, ys);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  val [4];
    idx = '{REG_SPARE, REG_SOURCE_WIDTH, REG_X_STEP, REG_Y_STEP};
    val = '{CFG_DATA_W'($urandom), {16'($urandom), w}, xs, ys};
    for (int i = 0; i < 4; i++) begin
      write_enable   <= 1'b1;
      register_index <= idx[i];
      write_data     <= val[i];
      @(posedge clk);
    end
    write_enable <= 1'b0;
    gen_width = w;
    gen_xstep = xs;
    gen_ystep = ys;
  endtask

  // drain all pending words, then let trailing loads leave the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [SRC_WIDTH_W-1:0] w;
    logic [STEP_W-1:0]      xs, ys;
    int                     pick, start;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: zero steps, every sample lands on word 0
    prepare_and_sample('0, '0, FILL_MISSING);
    prepare_and_sample('1, '1, FILL_MISSING);
    send_load('0, '1);
    send_load(LAST_ADDR, '0);
    prepare_and_sample(10'd512, 9'd256, FILL_MISSING);
    settle();

    // row 1 column 1 lands on the last store word: right and lower reads wrap
    program_registers(11'd1024, {11'd511, 16'h8000}, {11'd1023, 16'h4000});
    prepare_and_sample(10'd1, 9'd1, FILL_ONES);
    prepare_and_sample('0, '0, FILL_MISSING);
    prepare_and_sample('1, '1, FILL_MISSING);

    for (int phase = 0; phase < 3; phase++) begin
      for (int seg = 0; seg < 3; seg++) begin
        settle();
        case (phase)
          0: begin send_idle_pct = 37; recv_idle_pct <= 88; end
          1: begin send_idle_pct = 88; recv_idle_pct <= 37; end
          default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
        endcase
        case (phase * 3 + seg)
          0: begin
            w  = 11'd1024;
            xs = STEP_W'(1 << FRACTION_BITS);
            ys = STEP_W'(1 << FRACTION_BITS);
          end
          1: begin w = 11'd2; xs = '1; ys = '1; end
          2: begin w = '0; xs = STEP_W'($urandom); ys = STEP_W'($urandom); end
          3: begin
            w  = 11'd1;
            xs = STEP_W'($urandom_range(0, 1 << 17));
            ys = STEP_W'($urandom_range(0, 1 << 17));
          end
          4: begin
            w  = '1;
            xs = STEP_W'($urandom_range(0, 1 << 17));
            ys = STEP_W'($urandom_range(0, 1 << 17));
          end
          5: begin
            w  = SRC_WIDTH_W'(2 * $urandom_range(1, 512));
            xs = STEP_W'($urandom_range(0, 1 << 18));
            ys = STEP_W'($urandom_range(0, 1 << 18));
          end
          6: begin w = 11'd640; xs = '0; ys = STEP_W'($urandom_range(0, 1 << 18)); end
          7: begin
            w  = SRC_WIDTH_W'($urandom);
            xs = STEP_W'($urandom);
            ys = STEP_W'($urandom);
          end
          default: begin
            w  = SRC_WIDTH_W'(2 * $urandom_range(1, 512));
            xs = STEP_W'($urandom_range(0, 1 << 16));
            ys = STEP_W'($urandom_range(0, 1 << 16));
          end
        endcase
        program_registers(w, xs, ys);

        start = words_sent;
        while (words_sent - start < ITEMS_PER_SETTING) begin
          pick = int'($urandom_range(99));
          if (pick < 55) begin
            prepare_and_sample(ROW_W'($urandom), COL_W'($urandom), FILL_MISSING);
          end else if (pick < 70) begin
            // overwrite a neighbor of the last position, then ask again
            send_load(neighbor_addr(last_row, last_col, int'($urandom_range(3))),
                      random_word());
            prepare_and_sample(last_row, last_col, FILL_MISSING);
          end else begin
            case ($urandom_range(9))
              0:       send_load('0, random_word());
              1:       send_load(LAST_ADDR, random_word());
              default: send_load(ADDR_W'($urandom), random_word());
            endcase
          end
        end
      end
    end

    settle();
    sb.report_leftovers();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
